### rtl/core/distance_relaxation_layout_defines.svh
// Assertion macros shared by the distance relaxation layout RTL
`ifndef DISTANCE_RELAXATION_LAYOUT_DEFINES_SVH
`define DISTANCE_RELAXATION_LAYOUT_DEFINES_SVH

// Same-cycle implication, checked on clk_i and held off during reset
`define DRL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("drl assertion failed");

// Next-cycle implication, checked on clk_i and held off during reset
`define DRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("drl assertion failed");

`endif

### rtl/core/drl_pkg.sv
// Types, constants and state encoding of the distance relaxation layout
package drl_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int N_W        = IDX_W + 1;
  localparam int MEM_AW     = 2 * IDX_W;
  localparam int POS_W      = 32;
  localparam int DIST_W     = 31;
  localparam int FORCE_W    = 48;
  localparam int PROD_W     = 64;
  localparam int ROOT_W     = 32;
  localparam int DIV_W      = 49;
  localparam int MOVE_SHIFT = 24;
  localparam int MOVE_W     = PROD_W - MOVE_SHIFT;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic signed [PROD_W-1:0] MOVE_GAIN  = 64'sd33554;
  localparam logic signed [PROD_W-1:0] MOVE_ROUND = 64'sd8388608;

  localparam logic [1:0] OP_LOAD_DIST  = 2'd0;
  localparam logic [1:0] OP_LOAD_POINT = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 1'd1;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [4:0]               row_index;
    logic [4:0]               col_index;
    logic [DIST_W-1:0]        target_distance;
    logic signed [POS_W-1:0]  load_x;
    logic signed [POS_W-1:0]  load_y;
  } in_item_t;

  typedef struct packed {
    logic [4:0]               point_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_ROW, ST_PAIR, ST_SQX, ST_SQY, ST_SQS, ST_SQRT, ST_DIV,
    ST_MULX, ST_MULY, ST_ACCY, ST_NEXT, ST_MVX, ST_MVY, ST_UPD, ST_EMIT
  } state_e;

endpackage

### rtl/core/drl_if.sv
// Valid/ready stream interfaces for the input and result channels
interface drl_in_if;
  logic               valid;
  logic               ready;
  drl_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface drl_out_if;
  logic               valid;
  logic               ready;
  drl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/drl_isqrt.sv
// Iterative integer square root, two radicand bits per cycle
module drl_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [drl_pkg::PROD_W-1:0]   radicand_i,
  output logic [drl_pkg::ROOT_W-1:0]   root_o,
  output drl_pkg::unit_stat_t          stat_o
);

  localparam int CNT_W = $clog2(drl_pkg::ROOT_W);
  localparam int REM_W = drl_pkg::ROOT_W + 3;

  logic [drl_pkg::PROD_W-1:0] rad_q;
  logic [REM_W-1:0]           rem_q;
  logic [drl_pkg::ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q, done_q;

  logic [REM_W-1:0] rem_sh, trial;
  logic             fit;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[drl_pkg::PROD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(drl_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fit ? rem_sh - trial : rem_sh;
      root_q <= {root_q[drl_pkg::ROOT_W-2:0], fit};
    end
  end

  assign root_o = root_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

### rtl/core/drl_div.sv
// Iterative restoring divider, one quotient bit per cycle
module drl_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [drl_pkg::DIV_W-1:0]    num_i,
  input  logic [drl_pkg::ROOT_W-1:0]   den_i,
  output logic [drl_pkg::DIV_W-1:0]    quo_o,
  output drl_pkg::unit_stat_t          stat_o
);

  localparam int CNT_W = $clog2(drl_pkg::DIV_W);
  localparam int DW    = drl_pkg::ROOT_W;

  logic [drl_pkg::DIV_W-1:0] num_q;
  logic [DW-1:0]             rem_q, den_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;

  logic [DW:0] rem_sh;
  logic        fit;

  assign rem_sh = {rem_q, num_q[drl_pkg::DIV_W-1]};
  assign fit    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(drl_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in at the bottom as numerator bits leave the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fit ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
      num_q <= {num_q[drl_pkg::DIV_W-2:0], fit};
    end
  end

  assign quo_o  = num_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

### rtl/core/distance_relaxation_layout.sv
// Distance relaxation layout: sequencer, shared multiplier, stores and result register
//
// Channels: in_i takes load and run items (valid/ready), out_o returns one item
// per point after a run, with last set on the final point. Registers num_points
// (index 0) and step_count (index 1) are written on cfg_we_i; write them only
// while the block is idle.
// Loads are taken in the idle state and return nothing. A run with N points and S
// steps evaluates N*(N-1) pairs per step; each pair passes through the square root
// unit and then the divider in series, plus offset, square and force work (the
// divide is skipped when the two points coincide). Each row adds a ROW state, the
// self pair PAIR and NEXT, and each point's move MVX, MVY and UPD per step.
// Results then leave at one per cycle while the receiver is ready. in_i is
// not ready from the run's acceptance until its last result is loaded into the
// output register. After reset the target distance memory is cleared one entry
// a cycle, and in_i is not ready meanwhile; positions reset to zero, num_points
// to 32, step_count to 1. A stalled receiver holds the output register and the
// run waits; loads are taken while a finished result still waits.
`include "distance_relaxation_layout_defines.svh"

module distance_relaxation_layout (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [drl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [drl_pkg::STEP_W-1:0]       cfg_data_i,
  drl_in_if.sink                           in_i,
  drl_out_if.source                        out_o
);

  localparam int IW = drl_pkg::IDX_W;
  localparam int PW = drl_pkg::POS_W;
  localparam int FW = drl_pkg::FORCE_W;
  localparam int QW = drl_pkg::PROD_W;
  localparam int MW = drl_pkg::MOVE_W;

  function automatic logic signed [FW-1:0] sat48(input logic signed [FW:0] v);
    logic signed [FW-1:0] r;
    if (v[FW] != v[FW-1]) r = v[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    else r = v[FW-1:0];
    return r;
  endfunction

  function automatic logic signed [PW-1:0] sat32(input logic signed [MW:0] v);
    logic signed [PW-1:0] r;
    if (v > (MW+1)'(41'sh7FFFFFFF)) r = {1'b0, {(PW-1){1'b1}}};
    else if (v < -(MW+1)'(41'sh80000000)) r = {1'b1, {(PW-1){1'b0}}};
    else r = v[PW-1:0];
    return r;
  endfunction

  drl_pkg::state_e state_q, state_d;

  logic [drl_pkg::N_W-1:0]    num_points_q;
  logic [drl_pkg::STEP_W-1:0] step_count_q, step_q;
  logic [drl_pkg::MEM_AW-1:0] clr_q;
  logic [IW-1:0]              i_q, j_q;

  logic signed [PW-1:0] pos_x_q [drl_pkg::MAX_POINTS];
  logic signed [PW-1:0] pos_y_q [drl_pkg::MAX_POINTS];
  logic signed [FW-1:0] force_x_q [drl_pkg::MAX_POINTS];
  logic signed [FW-1:0] force_y_q [drl_pkg::MAX_POINTS];

  logic [drl_pkg::DIST_W-1:0] dist_mem [2**drl_pkg::MEM_AW];
  logic [drl_pkg::DIST_W-1:0] dist_rd_q, t_q;

  logic signed [PW-1:0] pix_q, piy_q, dx_q, dy_q, f_q;
  logic signed [QW-1:0] prod_q;
  logic [QW-1:0]        sq_q;
  logic signed [FW-1:0] fx_q, fy_q;
  logic signed [MW-1:0] mvx_q, mvy_q;

  logic                 out_valid_q;
  drl_pkg::out_item_t   out_q;

  // Control strobes
  logic in_ready, in_acc, mem_we, sq_start, dv_start, out_load, force_we, slot_free;
  logic [drl_pkg::MEM_AW-1:0] mem_addr;
  logic [drl_pkg::DIST_W-1:0] mem_wdata;

  logic [drl_pkg::N_W-1:0] n_use;
  logic [IW-1:0]           n_last;
  logic                    step_last;

  assign n_use     = (num_points_q > drl_pkg::N_W'(drl_pkg::MAX_POINTS))
                     ? drl_pkg::N_W'(drl_pkg::MAX_POINTS) : num_points_q;
  assign n_last    = IW'(n_use - 1'b1);
  assign step_last = step_q == step_count_q - 1'b1;
  assign slot_free = !out_valid_q || out_o.ready;

  // Single position read port
  logic [IW-1:0]        rd_idx;
  logic signed [PW-1:0] rd_x, rd_y;
  assign rd_idx = (state_q == drl_pkg::ST_PAIR) ? j_q : i_q;
  assign rd_x   = pos_x_q[rd_idx];
  assign rd_y   = pos_y_q[rd_idx];

  // Shared 32x32 multiplier
  logic signed [PW-1:0] mul_a, mul_b;
  logic signed [QW-1:0] mul_ax, mul_bx, mul_p;
  always_comb begin
    unique case (state_q)
      drl_pkg::ST_SQX:  begin mul_a = dx_q; mul_b = dx_q; end
      drl_pkg::ST_SQY:  begin mul_a = dy_q; mul_b = dy_q; end
      drl_pkg::ST_MULX: begin mul_a = f_q;  mul_b = dx_q; end
      default:          begin mul_a = f_q;  mul_b = dy_q; end
    endcase
  end
  assign mul_ax = QW'(mul_a);
  assign mul_bx = QW'(mul_b);
  assign mul_p  = mul_ax * mul_bx;

  // Move gain multiply, rounded and floor-shifted
  logic signed [FW-1:0] mv_f;
  logic signed [QW-1:0] mv_fx, mv_p;
  logic signed [MW-1:0] mv_r;
  assign mv_f  = (state_q == drl_pkg::ST_MVX) ? force_x_q[i_q] : force_y_q[i_q];
  assign mv_fx = QW'(mv_f);
  assign mv_p  = mv_fx * drl_pkg::MOVE_GAIN + drl_pkg::MOVE_ROUND;
  assign mv_r  = mv_p[QW-1:drl_pkg::MOVE_SHIFT];

  // Offsets to the current partner point
  logic signed [PW:0] ddx, ddy;
  assign ddx = {rd_x[PW-1], rd_x} - {pix_q[PW-1], pix_q};
  assign ddy = {rd_y[PW-1], rd_y} - {piy_q[PW-1], piy_q};

  // Force accumulation terms
  logic signed [FW-1:0] term;
  logic signed [FW:0]   acc_x, acc_y;
  assign term  = prod_q[QW-1:16];
  assign acc_x = {fx_q[FW-1], fx_q} + {term[FW-1], term};
  assign acc_y = {fy_q[FW-1], fy_q} + {term[FW-1], term};

  // Position update sums
  logic signed [MW:0] upd_x, upd_y;
  assign upd_x = (MW+1)'(rd_x) + (MW+1)'(mvx_q);
  assign upd_y = (MW+1)'(rd_y) + (MW+1)'(mvy_q);

  // Square root and divider
  drl_pkg::unit_stat_t        sq_stat, dv_stat;
  logic [drl_pkg::ROOT_W-1:0] root;
  logic [drl_pkg::DIV_W-1:0]  quo, num_mag;
  logic signed [PW:0]         diff;
  logic signed [drl_pkg::DIV_W-1:0] num_s;
  logic                       num_neg;
  logic signed [PW-1:0]       f_div;

  assign diff    = $signed({1'b0, root}) - $signed({2'b00, t_q});
  assign num_s   = {diff, 16'b0};
  assign num_neg = num_s[drl_pkg::DIV_W-1];
  assign num_mag = num_neg ? drl_pkg::DIV_W'(-num_s) : drl_pkg::DIV_W'(num_s);

  always_comb begin
    if (num_neg)
      f_div = (quo > drl_pkg::DIV_W'(49'h80000000)) ? {1'b1, {(PW-1){1'b0}}}
                                                    : PW'(~quo[PW-1:0] + 1'b1);
    else
      f_div = (quo > drl_pkg::DIV_W'(49'h7FFFFFFF)) ? {1'b0, {(PW-1){1'b1}}}
                                                    : quo[PW-1:0];
  end

  drl_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_q + prod_q),
    .root_o     (root),
    .stat_o     (sq_stat)
  );

  drl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (num_mag),
    .den_i  (root),
    .quo_o  (quo),
    .stat_o (dv_stat)
  );

  // Output strobes
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = {in_i.data.row_index, in_i.data.col_index};
    mem_wdata = in_i.data.target_distance;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    out_load  = 1'b0;
    force_we  = 1'b0;
    unique case (state_q)
      drl_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      drl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_i.valid && in_i.data.opcode == drl_pkg::OP_LOAD_DIST;
      end
      drl_pkg::ST_SQS:  sq_start = 1'b1;
      drl_pkg::ST_SQRT: dv_start = sq_stat.done && root != '0;
      drl_pkg::ST_NEXT: force_we = j_q == n_last;
      drl_pkg::ST_EMIT: out_load = slot_free;
      default: ;
    endcase
  end

  assign in_acc      = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drl_pkg::ST_CLEAR: if (&clr_q) state_d = drl_pkg::ST_IDLE;
      drl_pkg::ST_IDLE: begin
        if (in_acc && in_i.data.opcode == drl_pkg::OP_RUN && n_use != '0)
          state_d = (step_count_q == '0) ? drl_pkg::ST_EMIT : drl_pkg::ST_ROW;
      end
      drl_pkg::ST_ROW:  state_d = drl_pkg::ST_PAIR;
      drl_pkg::ST_PAIR: state_d = (j_q == i_q) ? drl_pkg::ST_NEXT : drl_pkg::ST_SQX;
      drl_pkg::ST_SQX:  state_d = drl_pkg::ST_SQY;
      drl_pkg::ST_SQY:  state_d = drl_pkg::ST_SQS;
      drl_pkg::ST_SQS:  state_d = drl_pkg::ST_SQRT;
      drl_pkg::ST_SQRT: begin
        if (sq_stat.done) state_d = (root == '0) ? drl_pkg::ST_MULX : drl_pkg::ST_DIV;
      end
      drl_pkg::ST_DIV:  if (dv_stat.done) state_d = drl_pkg::ST_MULX;
      drl_pkg::ST_MULX: state_d = drl_pkg::ST_MULY;
      drl_pkg::ST_MULY: state_d = drl_pkg::ST_ACCY;
      drl_pkg::ST_ACCY: state_d = drl_pkg::ST_NEXT;
      drl_pkg::ST_NEXT: begin
        if (j_q != n_last)      state_d = drl_pkg::ST_PAIR;
        else if (i_q != n_last) state_d = drl_pkg::ST_ROW;
        else                    state_d = drl_pkg::ST_MVX;
      end
      drl_pkg::ST_MVX:  state_d = drl_pkg::ST_MVY;
      drl_pkg::ST_MVY:  state_d = drl_pkg::ST_UPD;
      drl_pkg::ST_UPD: begin
        if (i_q != n_last)  state_d = drl_pkg::ST_MVX;
        else if (step_last) state_d = drl_pkg::ST_EMIT;
        else                state_d = drl_pkg::ST_ROW;
      end
      drl_pkg::ST_EMIT: if (out_load && i_q == n_last) state_d = drl_pkg::ST_IDLE;
      default: state_d = drl_pkg::ST_IDLE;
    endcase
  end

  // Control state, configuration and point positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= drl_pkg::ST_CLEAR;
      num_points_q <= drl_pkg::N_W'(drl_pkg::MAX_POINTS);
      step_count_q <= drl_pkg::STEP_W'(1);
      clr_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < drl_pkg::MAX_POINTS; k++) begin
        pos_x_q[k] <= '0;
        pos_y_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == drl_pkg::CFG_NUM_POINTS) num_points_q <= cfg_data_i[drl_pkg::N_W-1:0];
        else step_count_q <= cfg_data_i;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        drl_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
        drl_pkg::ST_IDLE: begin
          if (in_acc && in_i.data.opcode == drl_pkg::OP_LOAD_POINT) begin
            pos_x_q[in_i.data.row_index] <= in_i.data.load_x;
            pos_y_q[in_i.data.row_index] <= in_i.data.load_y;
          end
          if (in_acc && in_i.data.opcode == drl_pkg::OP_RUN) begin
            i_q    <= '0;
            step_q <= '0;
          end
        end
        drl_pkg::ST_ROW: j_q <= '0;
        drl_pkg::ST_NEXT: begin
          if (j_q != n_last) j_q <= j_q + 1'b1;
          else i_q <= (i_q == n_last) ? '0 : i_q + 1'b1;
        end
        drl_pkg::ST_UPD: begin
          pos_x_q[i_q] <= sat32(upd_x);
          pos_y_q[i_q] <= sat32(upd_y);
          if (i_q == n_last) begin
            i_q    <= '0;
            step_q <= step_last ? '0 : step_q + 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        drl_pkg::ST_EMIT: if (out_load) i_q <= (i_q == n_last) ? '0 : i_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Target distance memory
  always_ff @(posedge clk_i) begin
    if (mem_we) dist_mem[mem_addr] <= mem_wdata;
    dist_rd_q <= dist_mem[{i_q, j_q}];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      drl_pkg::ST_ROW: begin
        pix_q <= rd_x;
        piy_q <= rd_y;
        fx_q  <= '0;
        fy_q  <= '0;
      end
      drl_pkg::ST_PAIR: begin
        dx_q <= (ddx[PW] != ddx[PW-1]) ? {ddx[PW], {(PW-1){~ddx[PW]}}} : ddx[PW-1:0];
        dy_q <= (ddy[PW] != ddy[PW-1]) ? {ddy[PW], {(PW-1){~ddy[PW]}}} : ddy[PW-1:0];
      end
      drl_pkg::ST_SQX: begin
        prod_q <= mul_p;
        t_q    <= dist_rd_q;
      end
      drl_pkg::ST_SQY: begin
        prod_q <= mul_p;
        sq_q   <= prod_q;
      end
      drl_pkg::ST_SQRT: if (sq_stat.done && root == '0) f_q <= {1'b0, t_q};
      drl_pkg::ST_DIV:  if (dv_stat.done) f_q <= f_div;
      drl_pkg::ST_MULX: prod_q <= mul_p;
      drl_pkg::ST_MULY: begin
        prod_q <= mul_p;
        fx_q   <= sat48(acc_x);
      end
      drl_pkg::ST_ACCY: fy_q <= sat48(acc_y);
      drl_pkg::ST_NEXT: begin
        if (force_we) begin
          force_x_q[i_q] <= fx_q;
          force_y_q[i_q] <= fy_q;
        end
      end
      drl_pkg::ST_MVX: mvx_q <= mv_r;
      drl_pkg::ST_MVY: mvy_q <= mv_r;
      drl_pkg::ST_EMIT: begin
        if (out_load) begin
          out_q.point_index <= i_q;
          out_q.pos_x       <= rd_x;
          out_q.pos_y       <= rd_y;
          out_q.last        <= i_q == n_last;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `DRL_ASSERT_IMPL(a_last_index, out_valid_q && out_q.last, out_q.point_index == n_last)
  `DRL_ASSERT_IMPL(a_pair_range, state_q == drl_pkg::ST_PAIR, j_q <= n_last && i_q <= n_last)
  `DRL_ASSERT_IMPL(a_units_excl, sq_stat.busy, !dv_stat.busy)
  `DRL_ASSERT_NEXT(a_sqrt_runs, state_q == drl_pkg::ST_SQS, sq_stat.busy)

endmodule
